### rtl/core/wcrm_pkg.sv
// Shared types and constants for the windowed counter rate meter.
package wcrm_pkg;

  localparam int unsigned DefHistoryDepth = 1024;
  localparam int unsigned DefWindowCount  = 3;
  localparam int unsigned NumCtr          = 6;
  localparam int unsigned CtrW            = 64;
  localparam int unsigned TimeW           = 32;
  localparam int unsigned WinW            = 16;
  localparam int unsigned CfgIdxW         = 2;
  // Dividend is the 64-bit delta with 16 fraction bits appended.
  localparam int unsigned DivBits         = 80;
  localparam int unsigned DivCntW         = 7;

  localparam logic [CfgIdxW-1:0] RegShortWin = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMidWin   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLongWin  = 2'd2;

  localparam logic [WinW-1:0] ShortWinReset = 16'd60;
  localparam logic [WinW-1:0] MidWinReset   = 16'd300;
  localparam logic [WinW-1:0] LongWinReset  = 16'd900;

  typedef struct packed {
    logic [TimeW-1:0] now_s;
    logic [CtrW-1:0]  rd_sectors;
    logic [CtrW-1:0]  rd_ops;
    logic [CtrW-1:0]  rd_bytes;
    logic [CtrW-1:0]  wr_sectors;
    logic [CtrW-1:0]  wr_ops;
    logic [CtrW-1:0]  wr_bytes;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]      window_id;
    logic [CtrW-1:0] rd_sectors_rate;
    logic [CtrW-1:0] rd_ops_rate;
    logic [CtrW-1:0] rd_bytes_rate;
    logic [CtrW-1:0] wr_sectors_rate;
    logic [CtrW-1:0] wr_ops_rate;
    logic [CtrW-1:0] wr_bytes_rate;
    logic            no_base;
    logic            last_window;
  } out_beat_t;

  typedef logic [NumCtr-1:0][CtrW-1:0] ctr_vec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_WIN_CHECK,
    ST_WIN_READ,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;        // capture input beat
    logic write;       // store sample into history
    logic scan_step;   // read next history slot
    logic win_check;   // evaluate base of current window
    logic base_latch;  // capture base counters
    logic div_load;    // start division for current counter
    logic div_step;    // one quotient bit
    logic next_win;    // advance to next window
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic win_ok;
    logic div_last;
    logic ctr_last;
    logic win_last;
  } dp_status_t;

endpackage

### rtl/core/wcrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wcrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/wcrm_ctrl.sv
// Sequencer for write, history scan, per-window division and result beats.
module wcrm_ctrl import wcrm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_WRITE;
      ST_WRITE:     state_next = ST_SCAN;
      ST_SCAN:      if (status.scan_last) state_next = ST_DRAIN;
      ST_DRAIN:     state_next = ST_WIN_CHECK;
      ST_WIN_CHECK: state_next = status.win_ok ? ST_WIN_READ : ST_OUT;
      ST_WIN_READ:  state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (status.div_last) state_next = status.ctr_last ? ST_OUT : ST_DIV_LOAD;
      end
      ST_OUT: begin
        if (!out_stall) state_next = status.win_last ? ST_IDLE : ST_WIN_CHECK;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_WRITE:     cmd.write = 1'b1;
      ST_SCAN:      cmd.scan_step = 1'b1;
      ST_DRAIN:     ;
      ST_WIN_CHECK: cmd.win_check = 1'b1;
      ST_WIN_READ:  cmd.base_latch = 1'b1;
      ST_DIV_LOAD:  cmd.div_load = 1'b1;
      ST_DIV_RUN:   cmd.div_step = 1'b1;
      ST_OUT: begin
        out_valid    = 1'b1;
        cmd.next_win = !out_stall;
      end
      default:      ;
    endcase
  end

endmodule

### rtl/core/wcrm_dp.sv
// Datapath: history memories, base search, serial divider, result register.
module wcrm_dp import wcrm_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = DefHistoryDepth,
  parameter int unsigned WINDOW_COUNT  = DefWindowCount
) (
  input  logic               clk,
  input  logic               rst,
  input  in_beat_t           in_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WinW-1:0]    cfg_data,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output out_beat_t          out_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  // window lengths
  logic [2:0][WinW-1:0] win_len;

  // captured sample
  logic [TimeW-1:0] now;
  ctr_vec_t         cur_ctr;

  // ring state
  logic [AW-1:0] write_slot;
  logic [AW:0]   fill;

  // scan
  logic [AW:0]      scan_idx;
  logic             rd_pend;
  logic [AW-1:0]    rd_slot;
  logic [TimeW-1:0] rd_time;

  logic [WINDOW_COUNT-1:0][TimeW:0]  best_time;
  logic [WINDOW_COUNT-1:0][AW-1:0]   best_slot;
  logic [WINDOW_COUNT-1:0]           found;

  // per-window
  logic [1:0]       win_idx;
  logic [TimeW-1:0] secs;
  logic [TimeW-1:0] divisor;
  ctr_vec_t         base_rd;
  ctr_vec_t         base;
  logic [2:0]       ctr_idx;
  ctr_vec_t         rate;
  logic             no_base;

  // divider
  logic [DivBits-1:0] dvd;
  logic [DivBits-1:0] quo;
  logic [DivBits-1:0] quo_next;
  logic [TimeW-1:0]   rem;
  logic [TimeW:0]     rem_sh;
  logic               q_bit;
  logic [DivCntW-1:0] bit_cnt;

  logic [AW-1:0] write_slot_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len[0] <= ShortWinReset;
      win_len[1] <= MidWinReset;
      win_len[2] <= LongWinReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegShortWin: win_len[0] <= cfg_data;
        RegMidWin:   win_len[1] <= cfg_data;
        RegLongWin:  win_len[2] <= cfg_data;
        default:     ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now        <= in_data.now_s;
      cur_ctr[0] <= in_data.rd_sectors;
      cur_ctr[1] <= in_data.rd_ops;
      cur_ctr[2] <= in_data.rd_bytes;
      cur_ctr[3] <= in_data.wr_sectors;
      cur_ctr[4] <= in_data.wr_ops;
      cur_ctr[5] <= in_data.wr_bytes;
    end
  end

  assign write_slot_next = (write_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : write_slot + 1'b1;

  // ring pointer and fill count; slots below fill have been written
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= AW'(HISTORY_DEPTH - 1);
      fill       <= '0;
    end else if (cmd.write) begin
      write_slot <= write_slot_next;
      if (fill != (AW+1)'(HISTORY_DEPTH)) fill <= fill + 1'b1;
    end
  end

  wcrm_ram #(.WIDTH(TimeW), .DEPTH(HISTORY_DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (write_slot_next),
    .wdata (now),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rd_time)
  );

  wcrm_ram #(.WIDTH(NumCtr*CtrW), .DEPTH(HISTORY_DEPTH)) u_ctr_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (write_slot_next),
    .wdata (cur_ctr),
    .raddr (best_slot[win_idx]),
    .rdata (base_rd)
  );

  // scan address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_step;
      if (cmd.write) scan_idx <= '0;
      else if (cmd.scan_step) scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= scan_idx[AW-1:0];
  end

  assign status.scan_last = (scan_idx == (AW+1)'(HISTORY_DEPTH - 1));

  // base search: oldest valid slot with now - len <= t < best
  for (genvar w = 0; w < WINDOW_COUNT; w++) begin : g_win
    logic hit;
    assign hit = rd_pend && ({1'b0, rd_slot} < fill) && (rd_time != '0) &&
                 (({1'b0, rd_time} + {{(TimeW+1-WinW){1'b0}}, win_len[w]}) >= {1'b0, now}) &&
                 ({1'b0, rd_time} < best_time[w]);
    always_ff @(posedge clk) begin
      if (cmd.write) begin
        best_time[w] <= {1'b0, now} + 1'b1;
        found[w]     <= 1'b0;
      end else if (hit) begin
        best_time[w] <= {1'b0, rd_time};
        best_slot[w] <= rd_slot;
        found[w]     <= 1'b1;
      end
    end
  end

  assign secs          = now - best_time[win_idx][TimeW-1:0];
  assign status.win_ok = found[win_idx] && (secs != '0);

  // window index
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      win_idx <= '0;
    end else if (cmd.next_win) begin
      win_idx <= win_idx + 1'b1;
    end
  end

  assign status.win_last = (win_idx == 2'(WINDOW_COUNT - 1));

  // per-window setup
  always_ff @(posedge clk) begin
    if (cmd.win_check) begin
      divisor <= secs;
      no_base <= !status.win_ok;
      ctr_idx <= '0;
      if (!status.win_ok) rate <= '0;
    end
    if (cmd.base_latch) base <= base_rd;
    if (cmd.div_step && status.div_last) begin
      rate[ctr_idx] <= (quo_next[DivBits-1:CtrW] != '0) ? '1 : quo_next[CtrW-1:0];
      ctr_idx       <= ctr_idx + 1'b1;
    end
  end

  assign status.ctr_last = (ctr_idx == 3'(NumCtr - 1));

  // restoring divider, one quotient bit per cycle
  assign rem_sh   = {rem, dvd[DivBits-1]};
  assign q_bit    = (rem_sh >= {1'b0, divisor});
  assign quo_next = {quo[DivBits-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd     <= {cur_ctr[ctr_idx] - base[ctr_idx], 16'h0000};
      rem     <= '0;
      quo     <= '0;
      bit_cnt <= '0;
    end else if (cmd.div_step) begin
      dvd     <= {dvd[DivBits-2:0], 1'b0};
      rem     <= q_bit ? TimeW'(rem_sh - {1'b0, divisor}) : rem_sh[TimeW-1:0];
      quo     <= quo_next;
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  assign status.div_last = (bit_cnt == DivCntW'(DivBits - 1));

  // result beat
  assign out_data.window_id       = win_idx;
  assign out_data.rd_sectors_rate = rate[0];
  assign out_data.rd_ops_rate     = rate[1];
  assign out_data.rd_bytes_rate   = rate[2];
  assign out_data.wr_sectors_rate = rate[3];
  assign out_data.wr_ops_rate     = rate[4];
  assign out_data.wr_bytes_rate   = rate[5];
  assign out_data.no_base         = no_base;
  assign out_data.last_window     = status.win_last;

endmodule

### rtl/core/windowed_counter_rate_meter.sv
// Sliding-window rate meter for six cumulative counters: top level.
//
// Input channel (in_valid/in_stall/in_data) takes one timestamped sample of
// six cumulative counters. Each beat is stored in a ring history of
// HISTORY_DEPTH entries; then the whole history is scanned once, one slot
// per cycle, to find the base sample of every window. For each window the
// six rates come from a shared restoring divider producing one quotient bit
// per cycle, and one result beat per window leaves on out_valid/out_stall/
// out_data, the final one flagged last_window. in_stall stays high until
// the last result beat of a sample is taken.
// While out_stall is high the result beat holds and the block waits.
// Reset sets the ring pointer to its last slot, clears the fill count (no
// memory sweep) and loads the window registers to 60, 300 and 900 seconds.
// cfg_we writes a window length at cfg_index; write only while idle.
module windowed_counter_rate_meter import wcrm_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = DefHistoryDepth,
  parameter int unsigned WINDOW_COUNT  = DefWindowCount
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_beat_t          out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WinW-1:0]    cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wcrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wcrm_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .WINDOW_COUNT  (WINDOW_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

### tb/testbench.sv
// Testbench for the windowed counter rate meter: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module testbench;
  import wcrm_pkg::*;

  localparam int unsigned Depth = DefHistoryDepth;
  localparam int unsigned NWin = DefWindowCount;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam logic [63:0] RateSat = 64'hFFFF_FFFF_FFFF_FFFF;

  // Rate predictor plus store of expected result beats
  class rate_scoreboard;
    bit [WinW-1:0] win_len[NWin];
    bit [TimeW-1:0] hist_time[Depth];
    bit [CtrW-1:0] hist_ctr[NumCtr][Depth];
    int unsigned slot;
    out_beat_t expected_q[$];
    int errors;
    int checked;

    function void clear();
      win_len[0] = ShortWinReset;
      win_len[1] = MidWinReset;
      win_len[2] = LongWinReset;
      slot = Depth - 1;
      foreach (hist_time[i]) hist_time[i] = '0;
      expected_q.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void set_window(logic [CfgIdxW-1:0] idx, logic [WinW-1:0] val);
      if (idx < NWin) win_len[idx] = val;
    endfunction

    function automatic bit [63:0] q16_rate(bit [63:0] delta, bit [63:0] secs);
      bit [63:0] q;
      bit [63:0] r;
      q = delta / secs;
      r = delta % secs;
      if (q >= (64'd1 << 48)) return RateSat;
      return (q << 16) + ((r << 16) / secs);
    endfunction

    // Store the sample, find each window's base and queue the three results
    function void note_sample(in_beat_t b);
      bit [CtrW-1:0] cur[NumCtr];
      bit [CtrW-1:0] rate[NumCtr];
      longint best_t[NWin];
      int best_s[NWin];
      longint t;
      longint lo;
      bit [63:0] secs;
      out_beat_t o;
      cur = '{b.rd_sectors, b.rd_ops, b.rd_bytes, b.wr_sectors, b.wr_ops, b.wr_bytes};
      slot = (slot + 1) % Depth;
      hist_time[slot] = b.now_s;
      for (int c = 0; c < NumCtr; c++) hist_ctr[c][slot] = cur[c];
      for (int w = 0; w < NWin; w++) begin
        best_t[w] = longint'(b.now_s) + 1;
        best_s[w] = -1;
      end
      for (int i = 0; i < Depth; i++) begin
        t = longint'(hist_time[i]);
        if (t == 0) continue;
        for (int w = 0; w < NWin; w++) begin
          lo = longint'(b.now_s) - longint'(win_len[w]);
          if (t >= lo && best_t[w] > t) begin
            best_t[w] = t;
            best_s[w] = i;
          end
        end
      end
      for (int w = 0; w < NWin; w++) begin
        secs = 0;
        if (best_s[w] >= 0) secs = 64'(b.now_s) - 64'(hist_time[best_s[w]]);
        for (int c = 0; c < NumCtr; c++)
          rate[c] = (best_s[w] < 0 || secs == 0) ? '0 :
                    q16_rate(cur[c] - hist_ctr[c][best_s[w]], secs);
        o.window_id = w[1:0];
        o.rd_sectors_rate = rate[0];
        o.rd_ops_rate = rate[1];
        o.rd_bytes_rate = rate[2];
        o.wr_sectors_rate = rate[3];
        o.wr_ops_rate = rate[4];
        o.wr_bytes_rate = rate[5];
        o.no_base = (best_s[w] < 0 || secs == 0);
        o.last_window = (w == NWin - 1);
        expected_q.push_back(o);
      end
    endfunction

    function void cmp(string name, bit [63:0] exp_v, bit [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: expected none actual %h", $time, a);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      cmp("window_id", e.window_id, a.window_id);
      cmp("rd_sectors_rate", e.rd_sectors_rate, a.rd_sectors_rate);
      cmp("rd_ops_rate", e.rd_ops_rate, a.rd_ops_rate);
      cmp("rd_bytes_rate", e.rd_bytes_rate, a.rd_bytes_rate);
      cmp("wr_sectors_rate", e.wr_sectors_rate, a.wr_sectors_rate);
      cmp("wr_ops_rate", e.wr_ops_rate, a.wr_ops_rate);
      cmp("wr_bytes_rate", e.wr_bytes_rate, a.wr_bytes_rate);
      cmp("no_base", e.no_base, a.no_base);
      cmp("last_window", e.last_window, a.last_window);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [WinW-1:0] cfg_data = '0;

  rate_scoreboard sb = new();
  int sent = 0;
  bit quiet = 1'b0;        // no idling on either side
  bit hold_done = 1'b0;

  windowed_counter_rate_meter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #80_000_000;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold-off, check each taken beat
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent >= 40) begin
        hold_done = 1'b1;
        hold = 6000;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!quiet && $urandom_range(0, 99) < 17);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Present one sample beat, with random idle cycles ahead of it
  task automatic send_sample(in_beat_t b);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_sample(b);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WinW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_window(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Let the block drain before touching the window registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic in_beat_t make_sample(logic [31:0] t, logic [63:0] base, logic [63:0] step);
    in_beat_t b;
    b.now_s = t;
    b.rd_sectors = base;
    b.rd_ops = base + step;
    b.rd_bytes = base * 512;
    b.wr_sectors = ~base;
    b.wr_ops = step;
    b.wr_bytes = base ^ step;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Well-formed run of rising time and growing counters; some noise beats
  task automatic random_run(int n, inout logic [31:0] t, inout logic [63:0] ctr[NumCtr]);
    in_beat_t b;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 80) begin
        t = t + $urandom_range(0, 4);
        if (t == 0) t = 1;
        for (int c = 0; c < NumCtr; c++)
          ctr[c] = ctr[c] + (rand64() >> $urandom_range(0, 63));
        b = {t, ctr[0], ctr[1], ctr[2], ctr[3], ctr[4], ctr[5]};
      end else begin
        b = {$urandom, rand64(), rand64(), rand64(), rand64(), rand64(), rand64()};
        if (b.now_s == 0) b.now_s = 32'hFFFF_FFFF;
      end
      quiet = (sent >= 120 && sent < 160);
      send_sample(b);
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [31:0] t;
    logic [63:0] ctr[NumCtr];
    sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: window past time zero, tie at equal time, wrap, saturation,
    // far-future stamp, later stamp behind stored ones, all-ones counters
    send_sample(make_sample(32'd1, 64'd0, 64'd0));
    send_sample(make_sample(32'd1, 64'd10, 64'd3));
    send_sample(make_sample(32'd2, 64'd1000, 64'd7));
    send_sample(make_sample(32'd3, 64'd5, 64'd1));
    send_sample(make_sample(32'd4, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF));
    send_sample(make_sample(32'd70, 64'h1234_5678, 64'd99));
    send_sample(make_sample(32'hFFFF_FFFF, '1, '1));
    send_sample(make_sample(32'd100, 64'd3, 64'd2));
    send_sample(make_sample(32'd101, '1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_sample(make_sample(32'd400, 64'd777, 64'd5));
    send_sample(make_sample(32'd1000, 64'hAAAA_5555_AAAA_5555, 64'h5555));

    wait_idle();
    write_reg(RegUnused, 16'd7);
    write_reg(RegShortWin, 16'd1);
    write_reg(RegMidWin, 16'd2);
    write_reg(RegLongWin, 16'hFFFF);
    t = 32'd1500;
    foreach (ctr[c]) ctr[c] = rand64();
    send_sample(make_sample(32'd1001, 64'd1, 64'd1));
    send_sample(make_sample(32'd1002, 64'd9, 64'd2));
    random_run(50, t, ctr);

    wait_idle();
    write_reg(RegShortWin, 16'hFFFF);
    write_reg(RegMidWin, 16'hFFFF);
    write_reg(RegLongWin, 16'hFFFF);
    t = $urandom;
    random_run(50, t, ctr);

    wait_idle();
    write_reg(RegShortWin, WinW'($urandom_range(1, 10)));
    write_reg(RegMidWin, WinW'($urandom_range(1, 100)));
    write_reg(RegLongWin, WinW'($urandom_range(1, 65535)));
    random_run(50, t, ctr);

    wait_idle();
    write_reg(RegShortWin, ShortWinReset);
    write_reg(RegMidWin, MidWinReset);
    write_reg(RegLongWin, LongWinReset);
    random_run(50, t, ctr);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d samples through five window settings, incl. extremes", sent);
    $display("Checked %0d rate results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
